>>> hw/rtl/alb_pkg.sv
// Shared types and constants for the antialiased line blend rasterizer.
`timescale 1ns / 1ps
package alb_pkg;

  localparam int unsigned MaxWidth   = 256;
  localparam int unsigned MaxHeight  = 256;
  localparam int unsigned StoreDepth = MaxWidth * MaxHeight;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam logic [10:0] CountMax   = 11'd1024;

  // Configuration register indexes.
  localparam logic [1:0] RegPixelFormat = 2'd0;
  localparam logic [1:0] RegWidth       = 2'd1;
  localparam logic [1:0] RegHeight      = 2'd2;

  typedef struct packed {
    logic               req_type;
    logic signed [11:0] start_x;
    logic signed [11:0] start_y;
    logic signed [11:0] end_x;
    logic signed [11:0] end_y;
    logic [23:0]        line_color;
    logic [8:0]         line_alpha;
  } req_t;

  typedef struct packed {
    logic [23:0] pixel_value;
    logic [10:0] pixels_written;
    logic        line_rejected;
  } rsp_t;

  // What the back end has to do with a queued item.
  typedef enum logic [1:0] {
    K_READ,
    K_EMPTY,
    K_REJECT,
    K_DRAW
  } kind_t;

  // Classified item: endpoints ordered along the major axis.
  typedef struct packed {
    kind_t              kind;
    logic               xmajor;
    logic [8:0]         a0;
    logic [8:0]         b0;
    logic [8:0]         a1;
    logic [8:0]         b1;
    logic signed [9:0]  dmin;
    logic [8:0]         dmaj;
    logic [23:0]        color;
    logic [8:0]         alpha;
  } job_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_PLOT,
    S_READ,
    S_MIX,
    S_RADDR,
    S_RMEM,
    S_DONE
  } bstate_t;

endpackage

>>> hw/rtl/antialiased_line_blend_raster.sv
// Top level of the antialiased line blend rasterizer.
`timescale 1ns / 1ps
// Usage:
// Request items arrive on in_valid/in_stall/in_item: a line draw or a read of
// one stored pixel. Each request gives exactly one result item on
// out_valid/out_stall/out_item, in request order.
// A front end classifies each item (read, read off screen, rejected line,
// draw) into a two-entry queue; a back end executes one job at a time.
// A read goes through the address and store-read states to the result
// register; a rejected line or an off-screen read goes straight to it. A draw
// takes the job, runs the restoring gradient divider (one quotient bit per
// cycle), then walks its plots: an off-screen plot skips the store, an
// on-screen plot does a read-modify-write of the single-port frame store.
// A line makes 2*(major-axis distance)+2 plots, or 4 for a zero-length line.
// Every job ends in the done state, which loads the result register.
// Reset returns the registers to 24-bit format and a 256 x 256 screen and
// starts a clearing pass over all 65536 store entries, one entry per cycle,
// during which in_stall is high. Configuration writes are taken at any time.
// When the receiver stalls, one result is held in the output register, the
// queue keeps taking requests until it is full, then in_stall rises.
module antialiased_line_blend_raster import alb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  req_t       in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output rsp_t       out_item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  logic [1:0] pixel_format;
  logic [8:0] screen_width, screen_height, eff_w, eff_h;
  logic       push, pop, q_full, q_empty, clearing;
  job_t       push_job, q_head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format  <= 2'd0;
      screen_width  <= 9'd256;
      screen_height <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegPixelFormat: pixel_format  <= cfg_data[1:0];
        RegWidth:       screen_width  <= cfg_data;
        RegHeight:      screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sizes above the store limit act as the limit.
  assign eff_w = (screen_width > 9'(MaxWidth)) ? 9'(MaxWidth) : screen_width;
  assign eff_h = (screen_height > 9'(MaxHeight)) ? 9'(MaxHeight) : screen_height;

  alb_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .eff_w    (eff_w),
    .eff_h    (eff_h),
    .q_full   (q_full),
    .clearing (clearing),
    .push     (push),
    .job      (push_job)
  );

  alb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  alb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pixel_format (pixel_format),
    .eff_w        (eff_w),
    .eff_h        (eff_h),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .pop          (pop),
    .clearing     (clearing),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item)
  );

endmodule

>>> hw/rtl/alb_front.sv
// Front end: accepts request items and classifies them into jobs.
`timescale 1ns / 1ps
module alb_front import alb_pkg::*; (
  input  logic       in_valid,
  output logic       in_stall,
  input  req_t       in_item,
  input  logic [8:0] eff_w,
  input  logic [8:0] eff_h,
  input  logic       q_full,
  input  logic       clearing,
  output logic       push,
  output job_t       job
);

  logic signed [12:0] x1, y1, x2, y2, w13, h13, dx13, dy13;
  logic signed [9:0]  dx, dy;
  logic [8:0]         adx, ady;
  logic               xm, swap, rej, rd_in;

  assign in_stall = q_full | clearing;
  assign push     = in_valid & ~in_stall;

  always_comb begin
    x1   = 13'(in_item.start_x);
    y1   = 13'(in_item.start_y);
    x2   = 13'(in_item.end_x);
    y2   = 13'(in_item.end_y);
    w13  = $signed({4'b0, eff_w});
    h13  = $signed({4'b0, eff_h});
    rd_in = (x1 >= 0) && (x1 < w13) && (y1 >= 0) && (y1 < h13);
    rej  = (x1 < 0) || (x1 > w13) || (x2 < 0) || (x2 > w13) ||
           (y1 < 0) || (y1 > h13) || (y2 < 0) || (y2 > h13);
    // Deltas fit ten bits once both endpoints are on screen.
    dx13 = x2 - x1;
    dy13 = y2 - y1;
    dx   = dx13[9:0];
    dy   = dy13[9:0];
    adx  = dx[9] ? 9'(-dx) : dx[8:0];
    ady  = dy[9] ? 9'(-dy) : dy[8:0];
    xm   = adx > ady;
    swap = xm ? dx[9] : dy[9];

    job.xmajor = xm;
    job.color  = in_item.line_color;
    job.alpha  = in_item.line_alpha;
    job.dmaj   = xm ? adx : ady;
    if (xm) begin
      job.a0   = swap ? x2[8:0] : x1[8:0];
      job.b0   = swap ? y2[8:0] : y1[8:0];
      job.a1   = swap ? x1[8:0] : x2[8:0];
      job.b1   = swap ? y1[8:0] : y2[8:0];
      job.dmin = swap ? -dy : dy;
    end else begin
      job.a0   = swap ? y2[8:0] : y1[8:0];
      job.b0   = swap ? x2[8:0] : x1[8:0];
      job.a1   = swap ? y1[8:0] : y2[8:0];
      job.b1   = swap ? x1[8:0] : x2[8:0];
      job.dmin = swap ? -dx : dx;
    end

    // A read carries its position in the start fields.
    if (in_item.req_type) begin
      job.kind = rd_in ? K_READ : K_EMPTY;
      job.a0   = x1[8:0];
      job.b0   = y1[8:0];
    end else begin
      job.kind = rej ? K_REJECT : K_DRAW;
    end
  end

endmodule

>>> hw/rtl/alb_queue.sv
// Two-entry queue of classified jobs between front and back end.
`timescale 1ns / 1ps
module alb_queue import alb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  job_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign empty = (fill == 2'd0);
  assign full  = (fill == 2'd2);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

>>> hw/rtl/alb_back.sv
// Back end: gradient divider, Wu plot sequencer, frame store and result register.
`timescale 1ns / 1ps
module alb_back import alb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] pixel_format,
  input  logic [8:0] eff_w,
  input  logic [8:0] eff_h,
  input  logic       q_empty,
  input  job_t       q_head,
  output logic       pop,
  output logic       clearing,
  output logic       out_valid,
  input  logic       out_stall,
  output rsp_t       out_item
);

  bstate_t state, state_next;
  job_t    jb;

  logic [23:0]        mem [StoreDepth];
  logic [23:0]        rd_data, wdata;
  logic [AddrW-1:0]   addr_r, clr_cnt, mem_addr;
  logic               mem_we, mem_re;

  logic [9:0]         rem, t;
  logic [24:0]        nq, nq_next;
  logic [4:0]         div_cnt;
  logic signed [17:0] grad, grad_next;
  logic signed [26:0] pos;

  logic               in_ends, sub;
  logic [1:0]         end_idx;
  logic [9:0]         k;
  logic [10:0]        cnt;
  logic [8:0]         br;

  logic [10:0]        maj, mn, px, py;
  logic [8:0]         cov, f9;
  logic               neg, on_screen, finished, load_out;
  logic [7:0]         ax, ay;
  logic [16:0]        addr_prod;
  logic [17:0]        br_prod;
  logic [8:0]         br_next;

  // Channel unpacking and packing for the configured format.
  function automatic logic [23:0] unpack(input logic [1:0] fmt, input logic [23:0] c);
    unique case (fmt)
      2'd1:    unpack = {c[15:11], 3'b0, c[10:5], 2'b0, c[4:0], 3'b0};
      2'd2:    unpack = {c[14:10], 3'b0, c[9:5], 3'b0, c[4:0], 3'b0};
      default: unpack = c;
    endcase
  endfunction

  function automatic logic [23:0] pack(input logic [1:0] fmt, input logic [23:0] c);
    unique case (fmt)
      2'd1:    pack = {8'b0, c[23:19], c[15:10], c[7:3]};
      2'd2:    pack = {9'b0, c[23:19], c[15:11], c[7:3]};
      default: pack = c;
    endcase
  endfunction

  // old + floor((new - old) * b / 256) equals the two-product blend.
  function automatic logic [7:0] mix(input logic [7:0] o, input logic [7:0] n,
                                     input logic [8:0] b);
    logic signed [9:0]  d;
    logic signed [19:0] p;
    logic signed [19:0] s;
    d   = $signed({2'b0, n}) - $signed({2'b0, o});
    p   = 20'(d) * $signed({11'b0, b});
    s   = p >>> 8;
    mix = o + s[7:0];
  endfunction

  // One restoring division step, and the signed gradient it yields.
  always_comb begin
    t       = {rem[8:0], nq[24]};
    nq_next = {nq[23:0], t >= {1'b0, jb.dmaj}};
    if (jb.dmaj == 9'd0) begin
      grad_next = '0;
    end else if (jb.dmin < 0) begin
      grad_next = -$signed({1'b0, nq_next[16:0]});
    end else begin
      grad_next = $signed({1'b0, nq_next[16:0]});
    end
  end

  // Coordinates, coverage and on-screen test of the current plot.
  always_comb begin
    f9 = {1'b0, pos[15:8]};
    if (in_ends) begin
      maj = {2'b0, end_idx[1] ? jb.a1 : jb.a0};
      mn  = {2'b0, end_idx[1] ? jb.b1 : jb.b0} + 11'(end_idx[0]);
      cov = end_idx[0] ? 9'd0 : 9'd128;
      neg = 1'b0;
    end else begin
      maj = {1'b0, k};
      mn  = pos[26:16] + 11'(sub);
      cov = sub ? f9 : 9'd256 - f9;
      neg = pos[26];
    end
    px        = jb.xmajor ? maj : mn;
    py        = jb.xmajor ? mn : maj;
    on_screen = !neg && (px < {2'b0, eff_w}) && (py < {2'b0, eff_h});
    finished  = !in_ends && (k >= {1'b0, jb.a1});
    if (state == S_RADDR) begin
      ax = jb.a0[7:0];
      ay = jb.b0[7:0];
    end else begin
      ax = px[7:0];
      ay = py[7:0];
    end
    addr_prod = {9'b0, ay} * {8'b0, eff_w} + {9'b0, ax};
    br_prod   = cov * jb.alpha;
    br_next   = (br_prod[17:8] > 10'd256) ? 9'd256 : br_prod[16:8];
  end

  // Blend of the stored pixel with the line color.
  always_comb begin
    logic [23:0] o, n;
    o     = unpack(pixel_format, rd_data);
    n     = unpack(pixel_format, jb.color);
    wdata = pack(pixel_format, {mix(o[23:16], n[23:16], br),
                                mix(o[15:8], n[15:8], br),
                                mix(o[7:0], n[7:0], br)});
  end

  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) && !q_empty;
  assign load_out = (state == S_DONE) && (!out_valid || !out_stall);
  assign mem_we   = (state == S_CLEAR) || (state == S_MIX);
  assign mem_re   = (state == S_READ) || (state == S_RMEM);
  assign mem_addr = (state == S_CLEAR) ? clr_cnt : addr_r;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_cnt == '1) state_next = S_IDLE;
      S_IDLE: begin
        if (!q_empty) begin
          unique case (q_head.kind)
            K_READ:   state_next = S_RADDR;
            K_DRAW:   state_next = S_DIV;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_DIV:   if (div_cnt == 5'd24) state_next = S_PLOT;
      S_PLOT: begin
        if (finished) begin
          state_next = S_DONE;
        end else if (on_screen) begin
          state_next = S_READ;
        end
      end
      S_READ:  state_next = S_MIX;
      S_MIX:   state_next = S_PLOT;
      S_RADDR: state_next = S_RMEM;
      S_RMEM:  state_next = S_DONE;
      S_DONE:  if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Clear sweep counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == S_CLEAR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Frame store.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= (state == S_CLEAR) ? 24'd0 : wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  // Job datapath: divider, plot walk and pixel count.
  always_ff @(posedge clk) begin
    logic advance;
    advance = ((state == S_PLOT) && !finished && !on_screen) || (state == S_MIX);
    if (pop) begin
      jb      <= q_head;
      rem     <= '0;
      nq      <= {q_head.dmin[9] ? 9'(-q_head.dmin) : q_head.dmin[8:0], 16'b0};
      div_cnt <= '0;
      cnt     <= '0;
      in_ends <= 1'b1;
      end_idx <= '0;
      sub     <= 1'b0;
    end
    if (state == S_DIV) begin
      rem     <= (t >= {1'b0, jb.dmaj}) ? t - {1'b0, jb.dmaj} : t;
      nq      <= nq_next;
      div_cnt <= div_cnt + 1'b1;
      if (div_cnt == 5'd24) begin
        grad <= grad_next;
        pos  <= $signed({2'b0, jb.b0, 16'b0}) + 27'(grad_next);
      end
    end
    if ((state == S_PLOT) || (state == S_RADDR)) begin
      addr_r <= addr_prod[AddrW-1:0];
      br     <= br_next;
    end
    if ((state == S_MIX) && (cnt < CountMax)) begin
      cnt <= cnt + 1'b1;
    end
    if (advance) begin
      if (in_ends) begin
        if (end_idx == 2'd3) begin
          in_ends <= 1'b0;
          k       <= {1'b0, jb.a0} + 10'd1;
          sub     <= 1'b0;
        end else begin
          end_idx <= end_idx + 1'b1;
        end
      end else if (sub) begin
        sub <= 1'b0;
        k   <= k + 1'b1;
        pos <= pos + 27'(grad);
      end else begin
        sub <= 1'b1;
      end
    end
  end

  // Result register: holds one finished item while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item.pixel_value    <= (jb.kind == K_READ) ? rd_data : 24'd0;
      out_item.pixels_written <= (jb.kind == K_DRAW) ? cnt : 11'd0;
      out_item.line_rejected  <= (jb.kind == K_REJECT);
    end
  end

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the antialiased line blend rasterizer.
`timescale 1ns / 1ps
module tb_top;
  import alb_pkg::*;

  // Frame store mirror and line rasterizer used to predict each result.
  class blend_scoreboard;
    int unsigned fmt;
    int unsigned scr_w;
    int unsigned scr_h;
    logic [23:0] pixels [StoreDepth];
    rsp_t expected_q [$];
    int errors;

    function void clear_all();
      fmt = 0;
      scr_w = 256;
      scr_h = 256;
      foreach (pixels[i]) pixels[i] = '0;
      expected_q.delete();
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [8:0] data);
      if (idx == RegPixelFormat) fmt = data[1:0];
      else if (idx == RegWidth) scr_w = data;
      else if (idx == RegHeight) scr_h = data;
    endfunction

    function int eff_w();
      return (scr_w > MaxWidth) ? MaxWidth : scr_w;
    endfunction

    function int eff_h();
      return (scr_h > MaxHeight) ? MaxHeight : scr_h;
    endfunction

    function void split_rgb(logic [23:0] c, output int unsigned r, output int unsigned g,
                            output int unsigned b);
      if (fmt == 1) begin
        r = c[15:11] << 3;
        g = c[10:5] << 2;
        b = c[4:0] << 3;
      end else if (fmt == 2) begin
        r = c[14:10] << 3;
        g = c[9:5] << 3;
        b = c[4:0] << 3;
      end else begin
        r = c[23:16];
        g = c[15:8];
        b = c[7:0];
      end
    endfunction

    function logic [23:0] join_rgb(int unsigned r, int unsigned g, int unsigned b);
      int unsigned v;
      if (fmt == 1) v = ((r >> 3) << 11) | ((g >> 2) << 5) | (b >> 3);
      else if (fmt == 2) v = ((r >> 3) << 10) | ((g >> 3) << 5) | (b >> 3);
      else v = (r << 16) | (g << 8) | b;
      return v[23:0];
    endfunction

    function int unsigned mix_chan(int unsigned o, int unsigned n, int unsigned br);
      return (o * (256 - br) + n * br) >> 8;
    endfunction

    // Blend one pixel; off-screen plots are dropped and not counted.
    function void blend_pixel(int x, int y, logic [23:0] col, int unsigned cov,
                              int unsigned alpha, ref int unsigned count);
      int unsigned br, idx, orr, og, ob, nr, ng, nb;
      if (x < 0 || x >= eff_w() || y < 0 || y >= eff_h()) return;
      br = (cov * alpha) >> 8;
      if (br > 256) br = 256;
      idx = y * eff_w() + x;
      if (idx >= StoreDepth) return;
      split_rgb(pixels[idx], orr, og, ob);
      split_rgb(col, nr, ng, nb);
      pixels[idx] = join_rgb(mix_chan(orr, nr, br), mix_chan(og, ng, br), mix_chan(ob, nb, br));
      if (count < CountMax) count++;
    endfunction

    // Wu line along the major axis, with half coverage at both ends.
    function void wu_line(int x1, int y1, int x2, int y2, logic [23:0] col,
                          int unsigned alpha, ref int unsigned count);
      int dx, dy, adx, ady, t, grad, pos, ip;
      int unsigned f;
      bit xmaj;
      dx = x2 - x1;
      dy = y2 - y1;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      xmaj = adx > ady;
      if (xmaj ? (x2 < x1) : (y2 < y1)) begin
        t = x1; x1 = x2; x2 = t;
        t = y1; y1 = y2; y2 = t;
        dx = -dx; dy = -dy;
      end
      if (xmaj) grad = (dy * 65536) / dx;
      else grad = (dy == 0) ? 0 : (dx * 65536) / dy;
      if (xmaj) begin
        blend_pixel(x1, y1, col, 128, alpha, count);
        blend_pixel(x1, y1 + 1, col, 0, alpha, count);
        blend_pixel(x2, y2, col, 128, alpha, count);
        blend_pixel(x2, y2 + 1, col, 0, alpha, count);
        pos = y1 * 65536 + grad;
        for (int k = x1 + 1; k <= x2 - 1; k++) begin
          f = (pos & 32'hFFFF) >> 8;
          ip = pos >>> 16;
          blend_pixel(k, ip, col, 256 - f, alpha, count);
          blend_pixel(k, ip + 1, col, f, alpha, count);
          pos += grad;
        end
      end else begin
        blend_pixel(x1, y1, col, 128, alpha, count);
        blend_pixel(x1 + 1, y1, col, 0, alpha, count);
        blend_pixel(x2, y2, col, 128, alpha, count);
        blend_pixel(x2 + 1, y2, col, 0, alpha, count);
        pos = x1 * 65536 + grad;
        for (int k = y1 + 1; k <= y2 - 1; k++) begin
          f = (pos & 32'hFFFF) >> 8;
          ip = pos >>> 16;
          blend_pixel(ip, k, col, 256 - f, alpha, count);
          blend_pixel(ip + 1, k, col, f, alpha, count);
          pos += grad;
        end
      end
    endfunction

    // Note one accepted request and queue its expected result.
    function void note_request(req_t r);
      int x1, y1, x2, y2, w, h;
      int unsigned count;
      rsp_t e;
      x1 = r.start_x;
      y1 = r.start_y;
      x2 = r.end_x;
      y2 = r.end_y;
      w = eff_w();
      h = eff_h();
      count = 0;
      e = '0;
      if (r.req_type) begin
        if (x1 >= 0 && x1 < w && y1 >= 0 && y1 < h && (y1 * w + x1) < StoreDepth)
          e.pixel_value = pixels[y1 * w + x1];
      end else if (x1 < 0 || x1 > w || x2 < 0 || x2 > w || y1 < 0 || y1 > h ||
                   y2 < 0 || y2 > h) begin
        e.line_rejected = 1'b1;
      end else begin
        wu_line(x1, y1, x2, y2, r.line_color, r.line_alpha, count);
      end
      e.pixels_written = count[10:0];
      expected_q.push_back(e);
    endfunction

    function void report(string what, int unsigned got, int unsigned want);
      errors++;
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endfunction

    // Compare one result item with the oldest expectation.
    function void check_result(rsp_t got);
      rsp_t e;
      if (expected_q.size() == 0) begin
        report("unexpected result", 32'(got.pixel_value), 0);
        return;
      end
      e = expected_q.pop_front();
      if (got.pixel_value !== e.pixel_value) report("pixel_value", got.pixel_value, e.pixel_value);
      if (got.pixels_written !== e.pixels_written)
        report("pixels_written", got.pixels_written, e.pixels_written);
      if (got.line_rejected !== e.line_rejected)
        report("line_rejected", got.line_rejected, e.line_rejected);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  req_t in_item;
  logic out_valid;
  logic out_stall;
  rsp_t out_item;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;

  blend_scoreboard board;
  int send_idle_pct;
  int recv_idle_pct;
  int phase;
  int hold_cycles;
  bit hold_done;
  int quiet_cycles;

  antialiased_line_blend_raster i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver: random stall, plus one long hold-off in the pressure phase.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cycles <= 0;
      hold_done <= 1'b0;
    end else if (phase == 2 && !hold_done) begin
      hold_done <= 1'b1;
      hold_cycles <= 3000;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Check results and watch for progress.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) board.check_result(out_item);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_cycles > 0)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 200000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offer one item and wait until it is taken.
  task automatic send_item(req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item <= r;
    do @(posedge clk); while (in_stall);
    board.note_request(r);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.set_reg(idx, data);
  endtask

  // Let the block drain fully before touching the registers.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic req_t line_req(int x1, int y1, int x2, int y2, int col, int alpha);
    req_t r;
    r.req_type = 1'b0;
    r.start_x = 12'(x1);
    r.start_y = 12'(y1);
    r.end_x = 12'(x2);
    r.end_y = 12'(y2);
    r.line_color = 24'(col);
    r.line_alpha = 9'(alpha);
    return r;
  endfunction

  function automatic req_t read_req(int x, int y);
    req_t r;
    r = '0;
    r.req_type = 1'b1;
    r.start_x = 12'(x);
    r.start_y = 12'(y);
    r.end_x = 12'($urandom);
    r.end_y = 12'($urandom);
    r.line_color = 24'($urandom);
    r.line_alpha = 9'($urandom);
    return r;
  endfunction

  // Mostly short in-bounds lines, some long ones, some rejects and reads.
  function automatic req_t random_req();
    int w, h, x, y, sel, span;
    req_t r;
    w = board.eff_w();
    h = board.eff_h();
    sel = $urandom_range(99);
    span = ($urandom_range(19) == 0) ? 256 : 12;
    x = $urandom_range(w);
    y = $urandom_range(h);
    if (sel < 30) begin
      r = read_req($urandom_range(w), $urandom_range(h));
    end else if (sel < 40) begin
      r = line_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      r.req_type = 1'b0;
    end else begin
      r = line_req(x, y, $urandom_range((x + span > w) ? w : x + span, (x > span) ? x - span : 0),
                   $urandom_range((y + span > h) ? h : y + span, (y > span) ? y - span : 0),
                   $urandom, $urandom_range(($urandom_range(9) == 0) ? 511 : 256));
    end
    return r;
  endfunction

  initial begin
    board = new();
    board.clear_all();
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = RegPixelFormat;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    phase = -1;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, reads, rejects, zero-length and steep lines.
    send_item(line_req(0, 0, 256, 256, 24'hFFFFFF, 256));
    send_item(line_req(0, 10, 255, 12, 24'hFF0000, 511));
    send_item(line_req(5, 5, 5, 5, 24'h00FF00, 256));
    send_item(line_req(20, 0, 22, 200, 24'h0000FF, 128));
    send_item(line_req(30, 40, 30, 40, 24'hABCDEF, 0));
    send_item(line_req(-1, 0, 10, 10, 24'hFFFFFF, 256));
    send_item(line_req(0, 0, 257, 10, 24'hFFFFFF, 256));
    send_item(line_req(-2048, 2047, 2047, -2048, 24'hFFFFFF, 256));
    send_item(line_req(200, 100, 10, 90, 24'h123456, 300));
    send_item(line_req(256, 0, 0, 256, 24'h808080, 256));
    send_item(read_req(5, 5));
    send_item(read_req(0, 0));
    send_item(read_req(255, 255));
    send_item(read_req(-2048, 2047));
    send_item(read_req(2047, -2048));
    send_item(read_req(256, 0));
    send_item(read_req(30, 40));

    // Random phases across formats and screen sizes.
    for (int ph = 0; ph < 9; ph++) begin
      wait_drained();
      case (ph % 3)
        0: begin send_idle_pct = 14; recv_idle_pct = 75; end
        1: begin send_idle_pct = 75; recv_idle_pct = 14; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_reg(RegPixelFormat, 9'(ph % 4));
      case (ph)
        1: begin write_reg(RegWidth, 9'd1); write_reg(RegHeight, 9'd1); end
        2: begin write_reg(RegWidth, 9'd511); write_reg(RegHeight, 9'd300); end
        4: begin write_reg(RegWidth, 9'd0); write_reg(RegHeight, 9'd0); end
        5: begin write_reg(RegWidth, 9'd37); write_reg(RegHeight, 9'd200); end
        7: begin write_reg(RegWidth, 9'd256); write_reg(RegHeight, 9'd256); end
        default: begin
          write_reg(RegWidth, 9'($urandom_range(256, 1)));
          write_reg(RegHeight, 9'($urandom_range(256, 1)));
        end
      endcase
      cfg_we <= 1'b0;
      phase = ph;
      for (int n = 0; n < 110; n++) send_item(random_req());
    end

    // Drain and settle.
    in_valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
